### design/pwiu_pkg.sv
// shared types, constants and the exp2 root table for the power weighted upscaler
package pwiu_pkg;

    localparam int MAX_SRC_DIM_DEF = 64;
    localparam int MAX_DST_DIM_DEF = 4096;

    localparam int COORD_W    = 12;
    localparam int PIX_W      = 32;
    localparam int SRC_CFG_W  = 7;
    localparam int DST_CFG_W  = 13;
    localparam int POW_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TDATA_W    = 56;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH    = 3'd0,
        REG_SRC_HEIGHT   = 3'd1,
        REG_DST_WIDTH    = 3'd2,
        REG_DST_HEIGHT   = 3'd3,
        REG_WEIGHT_POWER = 3'd4
    } t_cfg_reg;

    typedef enum logic {
        OP_STORE   = 1'b0,
        OP_COMPUTE = 1'b1
    } t_op;

    // clamped dimensions minus one, as the datapath uses them
    typedef struct packed {
        logic [SRC_CFG_W-1:0] sw_m1;
        logic [SRC_CFG_W-1:0] sh_m1;
        logic [DST_CFG_W-1:0] dw_m1;
        logic [DST_CFG_W-1:0] dh_m1;
        logic [POW_W-1:0]     power;
    } t_cfg;

    typedef struct packed {
        t_op                op;
        logic               store_ok;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] xc;
        logic [COORD_W-1:0] yc;
        logic [PIX_W-1:0]   pix;
    } t_item;

    typedef logic [15:0][29:0] t_roots;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = v;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // successive square roots of one half in Q.30
    function automatic t_roots build_roots();
        t_roots      t;
        logic [63:0] prev;
        prev = isqrt64(64'd1 << 59);
        t[0] = prev[29:0];
        for (int j = 1; j < 16; j++) begin
            prev = isqrt64(prev << 30);
            t[j] = prev[29:0];
        end
        return t;
    endfunction

    localparam t_roots ROOTS = build_roots();

endpackage

### design/power_weighted_image_upscale_core.sv
// top level of the power weighted image upscaler: config registers and channel wiring
//
// s_axis carries items: tuser[0] = 0 stores pixel_in at (coord_x, coord_y) of the
// source image, tuser[0] = 1 requests destination pixel (coord_x, coord_y).
// m_axis returns one item per request: blended ARGB pixel and the request coords.
// the cfg channel writes src_width, src_height, dst_width, dst_height and
// weight_power by index 0..4; it is always ready, and the user must see that it is
// written only while idle; the block itself does not enforce this. items pass a
// 4-entry queue into a sequencer that runs one item at a time. a store is done in
// its idle step, so stores stream at one per clock while no request holds it. a
// request holds the sequencer to take it, for 35 steps of exact coordinate division,
// a setup, per neighbour 16 square root steps, 16 log2 squarings, 16 exp2 products
// and 5 single steps, a blend setup, 8 steps of the per-channel blend division and
// the load of the output register, which waits while an earlier result is not yet
// taken; an out-of-reach neighbour skips the square root, log2 and exp2 steps, an
// underflowed weight skips exp2, and an all-zero weight sum skips the division.
// while m_axis_tready is low the finished result waits in the output register
// and the queue keeps taking items until it holds four.
// reset clears control state and restores the register defaults; the source
// store is not cleared and holds unknown data until written.
module power_weighted_image_upscale_core #(
    parameter int MAX_SRC_DIM = pwiu_pkg::MAX_SRC_DIM_DEF,
    parameter int MAX_DST_DIM = pwiu_pkg::MAX_DST_DIM_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // coord_x, coord_y, pixel_in
    input  logic [pwiu_pkg::TDATA_W-1:0]    s_axis_tdata,
    // op
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // pixel_out, out_x, out_y
    output logic [pwiu_pkg::TDATA_W-1:0]    m_axis_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pwiu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pwiu_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [pwiu_pkg::SRC_CFG_W-1:0] r_src_width, r_src_height;
    logic [pwiu_pkg::DST_CFG_W-1:0] r_dst_width, r_dst_height;
    logic [pwiu_pkg::POW_W-1:0]     r_weight_power;

    pwiu_pkg::t_cfg  cfg;
    pwiu_pkg::t_item front_item, q_item;
    logic            push, q_ready, q_valid, q_pop;
    int              sw_i, sh_i, dw_i, dh_i;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width    <= 7'd64;
            r_src_height   <= 7'd64;
            r_dst_width    <= 13'd128;
            r_dst_height   <= 13'd128;
            r_weight_power <= '0;
        end else if (i_cfg_valid) begin
            unique case (pwiu_pkg::t_cfg_reg'(i_cfg_index))
                pwiu_pkg::REG_SRC_WIDTH:    r_src_width    <= i_cfg_data[6:0];
                pwiu_pkg::REG_SRC_HEIGHT:   r_src_height   <= i_cfg_data[6:0];
                pwiu_pkg::REG_DST_WIDTH:    r_dst_width    <= i_cfg_data[12:0];
                pwiu_pkg::REG_DST_HEIGHT:   r_dst_height   <= i_cfg_data[12:0];
                pwiu_pkg::REG_WEIGHT_POWER: r_weight_power <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // dimensions saturated to [2, max]
    always_comb begin
        sw_i = (r_src_width < 7'd2) ? 2
             : ((int'(r_src_width) > MAX_SRC_DIM) ? MAX_SRC_DIM : int'(r_src_width));
        sh_i = (r_src_height < 7'd2) ? 2
             : ((int'(r_src_height) > MAX_SRC_DIM) ? MAX_SRC_DIM : int'(r_src_height));
        dw_i = (r_dst_width < 13'd2) ? 2
             : ((int'(r_dst_width) > MAX_DST_DIM) ? MAX_DST_DIM : int'(r_dst_width));
        dh_i = (r_dst_height < 13'd2) ? 2
             : ((int'(r_dst_height) > MAX_DST_DIM) ? MAX_DST_DIM : int'(r_dst_height));
        cfg.sw_m1 = 7'(sw_i - 1);
        cfg.sh_m1 = 7'(sh_i - 1);
        cfg.dw_m1 = 13'(dw_i - 1);
        cfg.dh_m1 = 13'(dh_i - 1);
        cfg.power = r_weight_power;
    end

    pwiu_front #(
        .MAX_SRC_DIM (MAX_SRC_DIM)
    ) u_front (
        .i_tvalid  (s_axis_tvalid),
        .o_tready  (s_axis_tready),
        .i_tdata   (s_axis_tdata),
        .i_tuser   (s_axis_tuser),
        .i_cfg     (cfg),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_item    (front_item)
    );

    pwiu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    pwiu_back #(
        .MAX_SRC_DIM (MAX_SRC_DIM)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata)
    );

endmodule

### design/pwiu_front.sv
// input side: unpacks items, checks store range and saturates destination coordinates
module pwiu_front #(
    parameter int MAX_SRC_DIM = pwiu_pkg::MAX_SRC_DIM_DEF
) (
    input  logic                         i_tvalid,
    output logic                         o_tready,
    input  logic [pwiu_pkg::TDATA_W-1:0] i_tdata,
    input  logic [0:0]                   i_tuser,
    input  pwiu_pkg::t_cfg               i_cfg,
    input  logic                         i_q_ready,
    output logic                         o_push,
    output pwiu_pkg::t_item              o_item
);

    logic [pwiu_pkg::COORD_W-1:0] cx;
    logic [pwiu_pkg::COORD_W-1:0] cy;

    assign cx = i_tdata[11:0];
    assign cy = i_tdata[23:12];

    always_comb begin
        o_item.op       = pwiu_pkg::t_op'(i_tuser[0]);
        o_item.store_ok = (int'(cx) < MAX_SRC_DIM) && (int'(cy) < MAX_SRC_DIM);
        o_item.cx       = cx;
        o_item.cy       = cy;
        o_item.xc       = ({1'b0, cx} > i_cfg.dw_m1) ? i_cfg.dw_m1[11:0] : cx;
        o_item.yc       = ({1'b0, cy} > i_cfg.dh_m1) ? i_cfg.dh_m1[11:0] : cy;
        o_item.pix      = i_tdata[55:24];
    end

    assign o_tready = i_q_ready;
    assign o_push   = i_tvalid & i_q_ready;

endmodule

### design/pwiu_queue.sv
// short item queue between the front and the back end
module pwiu_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pwiu_pkg::t_item i_item,
    output logic            o_ready,
    output logic            o_valid,
    output pwiu_pkg::t_item o_item,
    input  logic            i_pop
);

    localparam int DEPTH = pwiu_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pwiu_pkg::t_item    r_slot [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_count;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_slot[r_wr] <= i_item;
                r_wr         <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CNT_W'(DEPTH)) |-> !i_push)
        else $error("queue push while full");

endmodule

### design/pwiu_back.sv
// back end: source store, coordinate mapping, weight sequencer, blend and output register
module pwiu_back #(
    parameter int MAX_SRC_DIM = pwiu_pkg::MAX_SRC_DIM_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pwiu_pkg::t_cfg               i_cfg,
    input  logic                         i_q_valid,
    input  pwiu_pkg::t_item              i_q_item,
    output logic                         o_q_pop,
    output logic                         o_tvalid,
    input  logic                         i_tready,
    output logic [pwiu_pkg::TDATA_W-1:0] o_tdata
);

    localparam int SAW       = (MAX_SRC_DIM > 1) ? $clog2(MAX_SRC_DIM) : 1;
    localparam int ADDR_W    = 2 * SAW;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    typedef enum logic [3:0] {
        S_IDLE, S_MAP, S_SETUP, S_DIST, S_SQRT, S_BASE, S_LOG,
        S_PMUL, S_EXP, S_WT, S_NEXT, S_BLEND, S_DIV, S_OUT
    } t_state;

    logic [31:0]        r_mem [MEM_DEPTH];
    logic [31:0]        r_mem_q;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;

    t_state             r_state;
    logic [5:0]         r_cnt;
    logic [1:0]         r_k;
    logic [11:0]        r_cx, r_cy;
    logic [34:0]        r_nx, r_ny;
    logic [13:0]        r_remx, r_remy;
    logic [22:0]        r_px, r_py;
    logic [6:0]         r_x0, r_x1, r_y0, r_y1;
    logic [31:0]        r_sq_v, r_sq_r, r_sq_bit;
    logic [3:0][16:0]   r_base;
    logic [3:0][16:0]   r_w;
    logic [3:0][31:0]   r_pix;
    logic               r_cap;
    logic [30:0]        r_m;
    logic [4:0]         r_n;
    logic [15:0]        r_frac;
    logic [24:0]        r_e;
    logic [30:0]        r_r;
    logic [3:0][26:0]   r_acc;
    logic [18:0]        r_total;
    logic [3:0][7:0]    r_q;
    logic [1:0]         r_best;
    logic               r_o_valid;
    logic [55:0]        r_o_data;

    // combinational helpers
    logic [18:0] num_x, num_y;
    logic [13:0] den_x, den_y, rem_x_sh, rem_y_sh;
    logic        ge_x, ge_y;
    logic [6:0]  ix, iy, xsel, ysel;
    logic [11:0] xsel12, ysel12;
    logic [22:0] posx, posy, dx, dy;
    logic [16:0] ox, oy;
    logic [34:0] d2;
    logic [31:0] sq_t;
    logic [16:0] base_c;
    logic [4:0]  n_c;
    logic [61:0] log_sq;
    logic [31:0] log_sq30;
    logic [20:0] neg_log;
    logic [36:0] e_prod;
    logic [60:0] exp_prod;
    logic [47:0] w_prod;
    logic [6:0]  w_shamt;
    logic [47:0] w_shifted;
    logic [18:0] total_c;
    logic [3:0][26:0] acc_c;
    logic [1:0]  best_c;
    logic [26:0] div_t;
    logic [3:0]  div_ge;
    logic [31:0] res_c;

    always_comb begin
        num_x    = 19'(i_q_item.xc) * 19'(i_cfg.sw_m1);
        num_y    = 19'(i_q_item.yc) * 19'(i_cfg.sh_m1);
        den_x    = {1'b0, i_cfg.dw_m1};
        den_y    = {1'b0, i_cfg.dh_m1};
        rem_x_sh = {r_remx[12:0], r_nx[34]};
        rem_y_sh = {r_remy[12:0], r_ny[34]};
        ge_x     = rem_x_sh >= den_x;
        ge_y     = rem_y_sh >= den_y;

        ix     = r_px[22:16];
        iy     = r_py[22:16];
        xsel   = r_k[0] ? r_x1 : r_x0;
        ysel   = r_k[1] ? r_y1 : r_y0;
        xsel12 = {5'b0, xsel};
        ysel12 = {5'b0, ysel};
        posx   = {xsel, 16'b0};
        posy   = {ysel, 16'b0};
        dx     = (r_px > posx) ? r_px - posx : posx - r_px;
        dy     = (r_py > posy) ? r_py - posy : posy - r_py;
        ox     = dx[16:0];
        oy     = dy[16:0];
        d2     = 35'(ox) * 35'(ox) + 35'(oy) * 35'(oy);

        sq_t   = r_sq_r + r_sq_bit;

        base_c = 17'h10000 - {1'b0, r_sq_r[15:0]};
        n_c    = '0;
        for (int i = 0; i < 17; i++) begin
            if (base_c[i]) n_c = 5'(i);
        end

        log_sq   = 62'(r_m) * 62'(r_m);
        log_sq30 = log_sq[61:30];

        neg_log = 21'h100000 - {r_n, r_frac};
        e_prod  = 37'(i_cfg.power) * 37'(neg_log);

        exp_prod = 61'(r_r) * 61'(pwiu_pkg::ROOTS[r_cnt[3:0]]);

        w_prod    = 48'(r_base[r_k]) * 48'(r_r);
        w_shamt   = 7'd30 + {1'b0, r_e[21:16]};
        w_shifted = w_prod >> w_shamt;

        total_c = 19'(r_w[0]) + 19'(r_w[1]) + 19'(r_w[2]) + 19'(r_w[3]);
        for (int ch = 0; ch < 4; ch++) begin
            acc_c[ch] = '0;
            for (int k = 0; k < 4; k++) begin
                acc_c[ch] = acc_c[ch] + 27'(r_w[k]) * 27'(r_pix[k][8*ch +: 8]);
            end
        end
        // ties keep the earlier neighbour
        best_c = 2'd0;
        for (int k = 1; k < 4; k++) begin
            if (r_base[k] > r_base[best_c]) best_c = 2'(k);
        end

        div_t = 27'(r_total) << (3'd7 - r_cnt[2:0]);
        for (int ch = 0; ch < 4; ch++) begin
            div_ge[ch] = r_acc[ch] >= div_t;
        end

        res_c = (r_total == '0) ? r_pix[r_best] : {r_q[3], r_q[2], r_q[1], r_q[0]};

        rd_addr = {ysel12[SAW-1:0], xsel12[SAW-1:0]};
        wr_addr = {i_q_item.cy[SAW-1:0], i_q_item.cx[SAW-1:0]};
    end

    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign o_tvalid = r_o_valid;
    assign o_tdata  = r_o_data;

    always_ff @(posedge i_clk) begin
        if (o_q_pop && (i_q_item.op == pwiu_pkg::OP_STORE) && i_q_item.store_ok) begin
            r_mem[wr_addr] <= i_q_item.pix;
        end
        r_mem_q <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_cap     <= 1'b0;
            r_cnt     <= '0;
            r_k       <= '0;
        end else begin
            r_cap <= (r_state == S_DIST);
            if (r_cap) begin
                r_pix[r_k] <= r_mem_q;
            end
            // the output step handles its own handshake
            if (r_o_valid && i_tready && (r_state != S_OUT)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid && (i_q_item.op == pwiu_pkg::OP_COMPUTE)) begin
                        r_cx    <= i_q_item.cx;
                        r_cy    <= i_q_item.cy;
                        r_nx    <= {num_x, 16'b0};
                        r_ny    <= {num_y, 16'b0};
                        r_remx  <= '0;
                        r_remy  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_MAP;
                    end
                end
                S_MAP: begin
                    r_remx <= ge_x ? rem_x_sh - den_x : rem_x_sh;
                    r_remy <= ge_y ? rem_y_sh - den_y : rem_y_sh;
                    r_px   <= {r_px[21:0], ge_x};
                    r_py   <= {r_py[21:0], ge_y};
                    r_nx   <= r_nx << 1;
                    r_ny   <= r_ny << 1;
                    r_cnt  <= r_cnt + 6'd1;
                    if (r_cnt == 6'd34) begin
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_x0    <= ix;
                    r_y0    <= iy;
                    r_x1    <= (ix == i_cfg.sw_m1) ? ix : ix + 7'd1;
                    r_y1    <= (iy == i_cfg.sh_m1) ? iy : iy + 7'd1;
                    r_k     <= '0;
                    r_state <= S_DIST;
                end
                S_DIST: begin
                    if (d2[34:32] != '0) begin
                        r_base[r_k] <= '0;
                        r_w[r_k]    <= '0;
                        r_state     <= S_NEXT;
                    end else begin
                        r_sq_v   <= d2[31:0];
                        r_sq_r   <= '0;
                        r_sq_bit <= 32'h4000_0000;
                        r_cnt    <= '0;
                        r_state  <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_sq_v >= sq_t) begin
                        r_sq_v <= r_sq_v - sq_t;
                        r_sq_r <= (r_sq_r >> 1) + r_sq_bit;
                    end else begin
                        r_sq_r <= r_sq_r >> 1;
                    end
                    r_sq_bit <= r_sq_bit >> 2;
                    r_cnt    <= r_cnt + 6'd1;
                    if (r_cnt == 6'd15) begin
                        r_state <= S_BASE;
                    end
                end
                S_BASE: begin
                    r_base[r_k] <= base_c;
                    r_n         <= n_c;
                    r_m         <= {14'b0, base_c} << (5'd30 - n_c);
                    r_frac      <= '0;
                    r_cnt       <= '0;
                    r_state     <= S_LOG;
                end
                S_LOG: begin
                    // one fraction bit of -log2 per squaring
                    if (log_sq30[31]) begin
                        r_m <= log_sq30[31:1];
                    end else begin
                        r_m <= log_sq30[30:0];
                    end
                    r_frac <= {r_frac[14:0], log_sq30[31]};
                    r_cnt  <= r_cnt + 6'd1;
                    if (r_cnt == 6'd15) begin
                        r_state <= S_PMUL;
                    end
                end
                S_PMUL: begin
                    r_e   <= e_prod[36:12];
                    r_r   <= 31'h4000_0000;
                    r_cnt <= '0;
                    if (e_prod[36:28] > 9'd32) begin
                        r_w[r_k] <= '0;
                        r_state  <= S_NEXT;
                    end else begin
                        r_state <= S_EXP;
                    end
                end
                S_EXP: begin
                    if (r_e[4'd15 - r_cnt[3:0]]) begin
                        r_r <= exp_prod[60:30];
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd15) begin
                        r_state <= S_WT;
                    end
                end
                S_WT: begin
                    r_w[r_k] <= w_shifted[16:0];
                    r_state  <= S_NEXT;
                end
                S_NEXT: begin
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_state <= S_BLEND;
                    end else begin
                        r_state <= S_DIST;
                    end
                end
                S_BLEND: begin
                    r_total <= total_c;
                    r_acc   <= acc_c;
                    r_best  <= best_c;
                    r_cnt   <= '0;
                    if (total_c == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    for (int ch = 0; ch < 4; ch++) begin
                        if (div_ge[ch]) begin
                            r_acc[ch] <= r_acc[ch] - div_t;
                        end
                        r_q[ch] <= {r_q[ch][6:0], div_ge[ch]};
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd7) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_o_valid || i_tready) begin
                        r_o_valid <= 1'b1;
                        r_o_data  <= {r_cy, r_cx, res_c};
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_total != '0))
        else $error("blend division entered with zero weight sum");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside the output step");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NEXT) |-> (r_w[r_k] <= 17'h10000))
        else $error("neighbour weight above one");

endmodule

### dv/tb_power_weighted_image_upscale_core.sv
// testbench for the power weighted image upscaler: directed table, random phases, predictor check
module tb_power_weighted_image_upscale_core;
    timeunit 1ns;
    timeprecision 1ps;

    // source rows filled at start; requests are kept to rows that hold data
    localparam int FILL_ROWS = 4;

    typedef struct {
        logic [31:0] pixel;
        logic [11:0] x;
        logic [11:0] y;
    } t_pixel_res;

    typedef struct {
        pwiu_pkg::t_op op;
        logic [11:0]   x;
        logic [11:0]   y;
        logic [31:0]   pix;
        bit            typed;
        logic [31:0]   want;
    } t_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [pwiu_pkg::TDATA_W-1:0]    s_axis_tdata;   // coord_x, coord_y, pixel_in
    logic [0:0]                      s_axis_tuser;   // op
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [pwiu_pkg::TDATA_W-1:0]    m_axis_tdata;   // pixel_out, out_x, out_y
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [pwiu_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [pwiu_pkg::CFG_DATA_W-1:0] i_cfg_data;

    power_weighted_image_upscale_core dut (.*);

    // shadow state
    logic [31:0]     src_img [4096];
    longint unsigned reg_sw, reg_sh, reg_dw, reg_dh, reg_pow;
    longint unsigned half_roots [16];
    t_pixel_res      pending_pixels [$];
    int              errors = 0;

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned neg_log2_q16(longint unsigned b);
        longint unsigned n, m, frac;
        n = 0;
        frac = 0;
        while (n < 16 && (b >> (n + 1)) != 0) n++;
        m = b << (30 - n);
        for (int bit_i = 15; bit_i >= 0; bit_i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac = frac | (64'd1 << bit_i);
            end
        end
        return (64'd16 << 16) - ((n << 16) | frac);
    endfunction

    function automatic longint unsigned base_weight(longint unsigned b, longint unsigned p);
        longint unsigned e, k, f, r;
        e = (p * neg_log2_q16(b)) >> 12;
        k = e >> 16;
        f = e & 64'hFFFF;
        r = 64'd1 << 30;
        if (k > 32) return 0;
        for (int j = 0; j < 16; j++)
            if ((f >> (15 - j)) & 1) r = (r * half_roots[j]) >> 30;
        return (b * r) >> (30 + k);
    endfunction

    function automatic longint unsigned clamp_dim(longint unsigned v, longint unsigned hi);
        if (v < 2) return 2;
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic [31:0] blend_pixel(longint unsigned cx, longint unsigned cy);
        longint unsigned sw, sh, dw, dh, xc, yc, num, ix, iy, px, py, total, acc, best;
        longint unsigned xs [2], ys [2], w [4], base [4], ox, oy, d2, sx, sy;
        logic [31:0] pix [4];
        logic [31:0] res;
        sw = clamp_dim(reg_sw, 64);
        sh = clamp_dim(reg_sh, 64);
        dw = clamp_dim(reg_dw, 4096);
        dh = clamp_dim(reg_dh, 4096);
        xc = (cx > dw - 1) ? dw - 1 : cx;
        yc = (cy > dh - 1) ? dh - 1 : cy;
        num = xc * (sw - 1);
        ix = num / (dw - 1);
        px = (ix << 16) + (((num % (dw - 1)) << 16) / (dw - 1));
        num = yc * (sh - 1);
        iy = num / (dh - 1);
        py = (iy << 16) + (((num % (dh - 1)) << 16) / (dh - 1));
        xs[0] = ix;
        xs[1] = (ix + 1 > sw - 1) ? sw - 1 : ix + 1;
        ys[0] = iy;
        ys[1] = (iy + 1 > sh - 1) ? sh - 1 : iy + 1;
        total = 0;
        for (int k = 0; k < 4; k++) begin
            sx = xs[k & 1];
            sy = ys[k >> 1];
            ox = (px > (sx << 16)) ? px - (sx << 16) : (sx << 16) - px;
            oy = (py > (sy << 16)) ? py - (sy << 16) : (sy << 16) - py;
            d2 = ox * ox + oy * oy;
            pix[k] = src_img[sy * 64 + sx];
            if (d2 >= (64'd1 << 32)) begin
                base[k] = 0;
                w[k] = 0;
            end else begin
                base[k] = 65536 - int_sqrt(d2);
                w[k] = base_weight(base[k], reg_pow);
            end
            total += w[k];
        end
        res = '0;
        if (total == 0) begin
            // every weight underflowed: nearest neighbour, first one on a tie
            best = 0;
            for (int k = 1; k < 4; k++) if (base[k] > base[best]) best = k;
            res = pix[best];
        end else begin
            for (int ch = 0; ch < 4; ch++) begin
                acc = 0;
                for (int k = 0; k < 4; k++) acc += w[k] * ((pix[k] >> (8 * ch)) & 8'hFF);
                acc = acc / total;
                if (acc > 255) acc = 255;
                res[8*ch +: 8] = acc[7:0];
            end
        end
        return res;
    endfunction

    task automatic idle_gap();
        int gap;
        gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_item(pwiu_pkg::t_op op, logic [11:0] x, logic [11:0] y,
                             logic [31:0] pix, bit typed, logic [31:0] want);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {pix, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        if (op == pwiu_pkg::OP_STORE) begin
            if (x < 64 && y < 64) src_img[y * 64 + x] = pix;
        end else begin
            pending_pixels.push_back('{typed ? want : blend_pixel(x, y), x, y});
        end
        idle_gap();
    endtask

    // wait until the block has nothing left in flight
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (pending_pixels.size() == 0);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(pwiu_pkg::t_cfg_reg idx, int unsigned raw, int fw);
        logic [15:0] data;
        data = 16'(raw) | (fw < 16 ? 16'($urandom) << fw : 16'd0);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            pwiu_pkg::REG_SRC_WIDTH:    reg_sw  = 64'(data & 16'h7F);
            pwiu_pkg::REG_SRC_HEIGHT:   reg_sh  = 64'(data & 16'h7F);
            pwiu_pkg::REG_DST_WIDTH:    reg_dw  = 64'(data & 16'h1FFF);
            pwiu_pkg::REG_DST_HEIGHT:   reg_dh  = 64'(data & 16'h1FFF);
            pwiu_pkg::REG_WEIGHT_POWER: reg_pow = 64'(data);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(int unsigned sw, int unsigned sh, int unsigned dw,
                              int unsigned dh, int unsigned pw);
        write_reg(pwiu_pkg::REG_SRC_WIDTH, sw, 7);
        write_reg(pwiu_pkg::REG_SRC_HEIGHT, sh, 7);
        write_reg(pwiu_pkg::REG_DST_WIDTH, dw, 13);
        write_reg(pwiu_pkg::REG_DST_HEIGHT, dh, 13);
        write_reg(pwiu_pkg::REG_WEIGHT_POWER, pw, 16);
    endtask

    task automatic random_items(int count);
        int unsigned dw, dh, sh, ylim;
        logic [11:0] x, y;
        dw = 32'(clamp_dim(reg_dw, 4096));
        dh = 32'(clamp_dim(reg_dh, 4096));
        sh = 32'(clamp_dim(reg_sh, 64));
        // highest request row whose mapped source rows are all filled
        if (sh <= FILL_ROWS) ylim = dh - 1;
        else ylim = (FILL_ROWS - 2) * (dh - 1) / (sh - 1);
        repeat (count) begin
            if ($urandom_range(0, 9) < 6) begin
                case ($urandom_range(0, 9))
                    0: begin
                        x = 12'($urandom);
                        y = (sh <= FILL_ROWS) ? 12'($urandom) : 12'($urandom_range(0, ylim));
                    end
                    1: begin
                        x = 12'(dw - 1);
                        y = 12'($urandom_range(0, ylim));
                    end
                    2: begin
                        x = 12'd1;
                        y = (ylim > 0) ? 12'd1 : 12'd0;
                    end
                    default: begin
                        x = 12'($urandom_range(0, dw - 1));
                        y = 12'($urandom_range(0, ylim));
                    end
                endcase
                send_item(pwiu_pkg::OP_COMPUTE, x, y, 32'($urandom), 1'b0, '0);
            end else begin
                if ($urandom_range(0, 7) == 0) begin
                    x = 12'($urandom);
                    y = 12'($urandom);
                end else begin
                    x = 12'($urandom_range(0, 63));
                    y = 12'($urandom_range(0, 63));
                end
                send_item(pwiu_pkg::OP_STORE, x, y, 32'($urandom), 1'b0, '0);
            end
        end
    endtask

    // result side: stall at random, mostly short, sometimes long
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 4) == 0) begin
                stall = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 120)
                                                     : $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_pixel_res exp_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected pixel %h at (%0d,%0d)", m_axis_tdata[31:0],
                       m_axis_tdata[43:32], m_axis_tdata[55:44]);
                errors++;
            end else begin
                exp_res = pending_pixels.pop_front();
                if (m_axis_tdata[31:0] !== exp_res.pixel) begin
                    $error("pixel_out expected %h actual %h", exp_res.pixel, m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[43:32] !== exp_res.x) begin
                    $error("out_x expected %0d actual %0d", exp_res.x, m_axis_tdata[43:32]);
                    errors++;
                end
                if (m_axis_tdata[55:44] !== exp_res.y) begin
                    $error("out_y expected %0d actual %0d", exp_res.y, m_axis_tdata[55:44]);
                    errors++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    initial begin
        t_row rows [$];
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        reg_sw = 64; reg_sh = 64; reg_dw = 128; reg_dh = 128; reg_pow = 0;
        half_roots[0] = int_sqrt(64'd1 << 59);
        for (int j = 1; j < 16; j++) half_roots[j] = int_sqrt(half_roots[j - 1] << 30);
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fill the first source rows; the table below writes the far corner it reads
        for (int i = 0; i < FILL_ROWS * 64; i++)
            send_item(pwiu_pkg::OP_STORE, 12'(i % 64), 12'(i / 64), 32'($urandom),
                      1'b0, '0);

        rows = '{
            '{pwiu_pkg::OP_STORE,   0,    0,    32'hFFFF_FFFF, 0, 0},
            '{pwiu_pkg::OP_STORE,   63,   63,   32'h0000_0000, 0, 0},
            '{pwiu_pkg::OP_STORE,   1,    0,    32'hA5A5_A5A5, 0, 0},
            '{pwiu_pkg::OP_STORE,   0,    1,    32'h5A5A_5A5A, 0, 0},
            '{pwiu_pkg::OP_STORE,   1,    1,    32'h8000_0001, 0, 0},
            // stores outside the array are dropped
            '{pwiu_pkg::OP_STORE,   64,   0,    32'h1234_5678, 0, 0},
            '{pwiu_pkg::OP_STORE,   0,    4095, 32'h1234_5678, 0, 0},
            '{pwiu_pkg::OP_STORE,   4095, 4095, 32'h1234_5678, 0, 0},
            '{pwiu_pkg::OP_COMPUTE, 0,    0,    32'h0,         1, 32'hFFFF_FFFF},
            '{pwiu_pkg::OP_COMPUTE, 127,  127,  32'h0,         1, 32'h0000_0000},
            // out of range request saturates but echoes the raw coords
            '{pwiu_pkg::OP_COMPUTE, 4095, 4095, 32'hFFFF_FFFF, 1, 32'h0000_0000},
            '{pwiu_pkg::OP_COMPUTE, 127,  0,    32'h0,         0, 0},
            '{pwiu_pkg::OP_COMPUTE, 1,    0,    32'h0,         0, 0},
            '{pwiu_pkg::OP_COMPUTE, 1,    1,    32'h0,         0, 0},
            '{pwiu_pkg::OP_COMPUTE, 0,    1,    32'h0,         0, 0},
            '{pwiu_pkg::OP_COMPUTE, 2048, 3,    32'h0,         0, 0},
            '{pwiu_pkg::OP_COMPUTE, 0,    0,    32'h0,         1, 32'hFFFF_FFFF}
        };
        foreach (rows[i])
            send_item(rows[i].op, rows[i].x, rows[i].y, rows[i].pix, rows[i].typed, rows[i].want);
        random_items(100);
        drain();

        set_config(2, 2, 2, 2, 0);
        random_items(90);
        drain();
        set_config(64, 64, 4096, 4096, 65535);
        random_items(100);
        drain();
        // below-range and above-range register values saturate
        set_config(0, 1, 0, 1, 4096);
        random_items(90);
        drain();
        set_config(127, 100, 8191, 5000, 12345);
        random_items(100);
        drain();
        // centre of a 2x2 source at top power: all weights underflow, tie on first
        set_config(2, 2, 3, 3, 65535);
        send_item(pwiu_pkg::OP_COMPUTE, 1, 1, 32'h0, 1'b0, '0);
        random_items(90);
        drain();
        repeat (3) begin
            set_config($urandom_range(2, 64), $urandom_range(2, 64),
                       $urandom_range(2, 300), $urandom_range(2, 300), $urandom);
            random_items(80);
            drain();
        end

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
